// File: sv/tmfp_pkg.sv
package tmfp_pkg;

   localparam int MAX_BODY     = 64;
   localparam int MAX_ID_CHARS = 8;
   localparam int BODY_CNT_W   = $clog2(MAX_BODY + 1);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] CSR_OWN_ID_CHARS   = 3'd0;
   localparam logic [2:0] CSR_OWN_ID_LENGTH  = 3'd1;
   localparam logic [2:0] CSR_PEER_ID_CHARS  = 3'd2;
   localparam logic [2:0] CSR_PEER_ID_LENGTH = 3'd3;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] PRINT_LO   = 8'd32;
   localparam logic [7:0] PRINT_HI   = 8'd126;

   localparam logic [3:0] KIND_POS       = 4'd6;
   localparam logic [3:0] MSG_PREFIX_LEN = 4'd11;
   localparam logic [3:0] ACK_PREFIX_LEN = 4'd12;
   localparam logic [3:0] SEQ_MAX_DIGITS = 4'd10;
   localparam logic [3:0] ID_POS_MAX     = 4'd15;

   typedef enum logic [5:0] {
      PH_PREFIX = 6'b000001,
      PH_SENDER = 6'b000010,
      PH_TARGET = 6'b000100,
      PH_SEQ    = 6'b001000,
      PH_BODY   = 6'b010000,
      PH_DEAD   = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_MSG  = 2'd1,
      KIND_ACK  = 2'd2
   } kind_type;

   typedef struct packed {
      logic                  is_verdict;
      logic [7:0]            body_char;
      kind_type              frame_kind;
      logic                  sender_is_peer;
      logic                  target_is_self;
      logic [31:0]           seq_number;
      logic [BODY_CNT_W-1:0] body_count;
      logic                  last_of_run;
   } rsp_type;

   // Up to two results per input beat; slot0 goes out first.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    slot0;
      rsp_type    slot1;
   } push_type;

   function automatic logic [7:0] msg_prefix_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = "S";
         4'd1:    c = "C";
         4'd2:    c = "B";
         4'd3:    c = "R";
         4'd4:    c = ",";
         4'd5:    c = "M";
         4'd6:    c = "S";
         4'd7:    c = "G";
         4'd8:    c = ",";
         4'd9:    c = "1";
         4'd10:   c = ",";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] ack_prefix_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = "S";
         4'd1:    c = "C";
         4'd2:    c = "B";
         4'd3:    c = "R";
         4'd4:    c = ",";
         4'd5:    c = "M";
         4'd6:    c = "A";
         4'd7:    c = "C";
         4'd8:    c = "K";
         4'd9:    c = ",";
         4'd10:   c = "1";
         4'd11:   c = ",";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// File: sv/tmfp_parse.sv
module tmfp_parse
   import tmfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  logic [7:0]  frame_byte,
   input  logic        end_of_frame,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data,
   output push_type    push
);

   logic [63:0] own_chars_ff, own_chars_in;
   logic [3:0]  own_len_ff, own_len_in;
   logic [63:0] peer_chars_ff, peer_chars_in;
   logic [3:0]  peer_len_ff, peer_len_in;

   phase_type             phase_ff, phase_in, phase_step;
   logic [3:0]            pos_ff, pos_in, pos_step, pos_inc;
   kind_type              kind_ff, kind_in, kind_step, kind_pick;
   logic                  sender_ff, sender_in, sender_step;
   logic                  target_ff, target_in, target_step;
   logic [31:0]           seq_ff, seq_in, seq_step;
   logic [3:0]            digits_ff, digits_in, digits_step;
   logic [BODY_CNT_W-1:0] body_len_ff, body_len_in, body_len_step;

   logic        bad;
   logic        prefix_ok;
   logic        emit_body;
   logic [35:0] seq_next;
   logic [7:0]  peer_char, own_char;
   kind_type    verdict_kind;
   rsp_type     body_res, verdict_res;

   always_comb begin
      own_chars_in  = own_chars_ff;
      own_len_in    = own_len_ff;
      peer_chars_in = peer_chars_ff;
      peer_len_in   = peer_len_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OWN_ID_CHARS:   own_chars_in  = csr_write_data;
            CSR_OWN_ID_LENGTH:  own_len_in    = csr_write_data[3:0];
            CSR_PEER_ID_CHARS:  peer_chars_in = csr_write_data;
            CSR_PEER_ID_LENGTH: peer_len_in   = csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   assign pos_inc   = pos_ff + 4'd1;
   assign peer_char = peer_chars_ff[{pos_ff[2:0], 3'b000} +: 8];
   assign own_char  = own_chars_ff[{pos_ff[2:0], 3'b000} +: 8];
   // seq * 10 + digit, with headroom to catch a value past 32 bits.
   assign seq_next  = {1'b0, seq_ff, 3'b000} + {3'b000, seq_ff, 1'b0}
                    + {32'd0, frame_byte[3:0] - CHAR_ZERO[3:0]};

   always_comb begin
      phase_step    = phase_ff;
      pos_step      = pos_ff;
      kind_step     = kind_ff;
      kind_pick     = kind_ff;
      sender_step   = sender_ff;
      target_step   = target_ff;
      seq_step      = seq_ff;
      digits_step   = digits_ff;
      body_len_step = body_len_ff;
      bad           = 1'b0;
      prefix_ok     = 1'b1;
      emit_body     = 1'b0;

      unique case (phase_ff)
         PH_PREFIX: begin
            if (pos_ff < KIND_POS) begin
               prefix_ok = (frame_byte == msg_prefix_char(pos_ff));
            end else if (pos_ff == KIND_POS) begin
               if (frame_byte == CHAR_A) begin
                  kind_pick = KIND_ACK;
               end else if (frame_byte == CHAR_S) begin
                  kind_pick = KIND_MSG;
               end else begin
                  prefix_ok = 1'b0;
               end
            end else if (kind_ff == KIND_MSG) begin
               prefix_ok = (pos_ff < MSG_PREFIX_LEN)
                         && (frame_byte == msg_prefix_char(pos_ff));
            end else begin
               prefix_ok = (pos_ff < ACK_PREFIX_LEN)
                         && (frame_byte == ack_prefix_char(pos_ff));
            end
            if (!prefix_ok) begin
               bad = 1'b1;
            end else begin
               kind_step = kind_pick;
               if ((kind_pick == KIND_MSG && pos_inc == MSG_PREFIX_LEN)
                   || (kind_pick == KIND_ACK && pos_inc == ACK_PREFIX_LEN)) begin
                  phase_step = PH_SENDER;
                  pos_step   = 4'd0;
               end else begin
                  pos_step = pos_inc;
               end
            end
         end
         PH_SENDER: begin
            if (frame_byte == CHAR_COMMA) begin
               sender_step = sender_ff && (pos_ff == peer_len_ff)
                           && (peer_len_ff <= 4'(MAX_ID_CHARS));
               pos_step    = 4'd0;
               phase_step  = PH_TARGET;
            end else begin
               sender_step = sender_ff && (pos_ff < 4'(MAX_ID_CHARS))
                           && (frame_byte == peer_char);
               pos_step    = (pos_ff == ID_POS_MAX) ? pos_ff : pos_inc;
            end
         end
         PH_TARGET: begin
            if (frame_byte == CHAR_COMMA) begin
               target_step = target_ff && (pos_ff == own_len_ff)
                           && (own_len_ff <= 4'(MAX_ID_CHARS));
               pos_step    = 4'd0;
               phase_step  = PH_SEQ;
            end else begin
               target_step = target_ff && (pos_ff < 4'(MAX_ID_CHARS))
                           && (frame_byte == own_char);
               pos_step    = (pos_ff == ID_POS_MAX) ? pos_ff : pos_inc;
            end
         end
         PH_SEQ: begin
            if (frame_byte == CHAR_COMMA) begin
               if (kind_ff == KIND_MSG && digits_ff != 4'd0) begin
                  phase_step = PH_BODY;
               end else begin
                  bad = 1'b1;
               end
            end else if (frame_byte >= CHAR_ZERO && frame_byte <= CHAR_NINE
                         && digits_ff < SEQ_MAX_DIGITS) begin
               if (seq_next[35:32] != 4'd0) begin
                  bad = 1'b1;
               end else begin
                  seq_step    = seq_next[31:0];
                  digits_step = digits_ff + 4'd1;
               end
            end else begin
               bad = 1'b1;
            end
         end
         PH_BODY: begin
            if (frame_byte >= PRINT_LO && frame_byte <= PRINT_HI
                && body_len_ff < BODY_CNT_W'(MAX_BODY)) begin
               body_len_step = body_len_ff + BODY_CNT_W'(1);
               emit_body     = 1'b1;
            end else begin
               bad = 1'b1;
            end
         end
         PH_DEAD: ;
         default: bad = 1'b1;
      endcase

      if (bad) begin
         phase_step = PH_DEAD;
      end
   end

   // The verdict looks at the state as it stands after this beat.
   always_comb begin
      verdict_kind = KIND_NONE;
      if (kind_step == KIND_MSG && phase_step == PH_BODY
          && body_len_step != '0) begin
         verdict_kind = KIND_MSG;
      end else if (kind_step == KIND_ACK && phase_step == PH_SEQ
                   && digits_step != 4'd0) begin
         verdict_kind = KIND_ACK;
      end

      body_res                = '0;
      body_res.body_char      = frame_byte;
      body_res.frame_kind     = KIND_NONE;
      body_res.last_of_run    = !end_of_frame;

      verdict_res             = '0;
      verdict_res.is_verdict  = 1'b1;
      verdict_res.frame_kind  = verdict_kind;
      verdict_res.last_of_run = 1'b1;
      if (verdict_kind != KIND_NONE) begin
         verdict_res.sender_is_peer = sender_step;
         verdict_res.target_is_self = target_step;
         verdict_res.seq_number     = seq_step;
      end
      if (verdict_kind == KIND_MSG) begin
         verdict_res.body_count = body_len_step;
      end

      push.count = {1'b0, emit_body} + {1'b0, end_of_frame};
      push.slot0 = emit_body ? body_res : verdict_res;
      push.slot1 = verdict_res;
   end

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      kind_in     = kind_ff;
      sender_in   = sender_ff;
      target_in   = target_ff;
      seq_in      = seq_ff;
      digits_in   = digits_ff;
      body_len_in = body_len_ff;
      if (step_en) begin
         if (end_of_frame) begin
            phase_in    = PH_PREFIX;
            pos_in      = 4'd0;
            kind_in     = KIND_NONE;
            sender_in   = 1'b1;
            target_in   = 1'b1;
            seq_in      = 32'd0;
            digits_in   = 4'd0;
            body_len_in = '0;
         end else begin
            phase_in    = phase_step;
            pos_in      = pos_step;
            kind_in     = kind_step;
            sender_in   = sender_step;
            target_in   = target_step;
            seq_in      = seq_step;
            digits_in   = digits_step;
            body_len_in = body_len_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_chars_ff  <= 64'd0;
         own_len_ff    <= 4'd1;
         peer_chars_ff <= 64'd0;
         peer_len_ff   <= 4'd1;
         phase_ff      <= PH_PREFIX;
         pos_ff        <= 4'd0;
         kind_ff       <= KIND_NONE;
         sender_ff     <= 1'b1;
         target_ff     <= 1'b1;
         seq_ff        <= 32'd0;
         digits_ff     <= 4'd0;
         body_len_ff   <= '0;
      end else begin
         own_chars_ff  <= own_chars_in;
         own_len_ff    <= own_len_in;
         peer_chars_ff <= peer_chars_in;
         peer_len_ff   <= peer_len_in;
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         kind_ff       <= kind_in;
         sender_ff     <= sender_in;
         target_ff     <= target_in;
         seq_ff        <= seq_in;
         digits_ff     <= digits_in;
         body_len_ff   <= body_len_in;
      end
   end

endmodule

// File: sv/tmfp_queue.sv
module tmfp_queue
   import tmfp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_en,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp
);

   rsp_type mem [QUEUE_DEPTH];

   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [1:0]             push_count;
   logic                   pop;

   // Room for the two results one beat can cause.
   assign room       = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign rsp_valid  = (count_ff != '0);
   assign rsp        = mem[rd_ptr_ff];
   assign pop        = rsp_valid && !rsp_stall;
   assign push_count = push_en ? push.count : 2'd0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in  = count_ff + QUEUE_CNT_W'(push_count) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem[wr_ptr_ff] <= push.slot0;
      end
      if (push_count == 2'd2) begin
         mem[wr_ptr_ff + QUEUE_PTR_W'(1)] <= push.slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/text_message_frame_parser_top.sv
// Channel   Direction  Handshake           Beat contents
// req       in         req_valid/stall     one frame byte and its end-of-frame mark
// rsp       out        rsp_valid/stall     one body byte or one end-of-frame verdict
// csr       in         csr_write_enable    one identifier register write
//
// One frame byte is parsed in the cycle it is accepted; its results go into a
// four-entry result queue and reach rsp behind any results queued before them.
// A byte may cause two results (last body byte and verdict), queued in that order.
// req_stall rises only while the queue lacks room for two results.
// Synchronous reset resets parser and queue; ID chars become 0, ID lengths 1.
module text_message_frame_parser_top
   import tmfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_frame_byte,
   input  logic                  req_end_of_frame,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_is_verdict,
   output logic [7:0]            rsp_body_char,
   output logic [1:0]            rsp_frame_kind,
   output logic                  rsp_sender_is_peer,
   output logic                  rsp_target_is_self,
   output logic [31:0]           rsp_seq_number,
   output logic [BODY_CNT_W-1:0] rsp_body_count,
   output logic                  rsp_last_of_run,
   input  logic                  csr_write_enable,
   input  logic [2:0]            csr_index,
   input  logic [63:0]           csr_write_data
);

   push_type push;
   rsp_type  rsp;
   logic     room;
   logic     step_en;

   assign req_stall = !room;
   assign step_en   = req_valid && room;

   tmfp_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .step_en          (step_en),
      .frame_byte       (req_frame_byte),
      .end_of_frame     (req_end_of_frame),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push             (push)
   );

   tmfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (step_en),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_is_verdict     = rsp.is_verdict;
   assign rsp_body_char      = rsp.body_char;
   assign rsp_frame_kind     = rsp.frame_kind;
   assign rsp_sender_is_peer = rsp.sender_is_peer;
   assign rsp_target_is_self = rsp.target_is_self;
   assign rsp_seq_number     = rsp.seq_number;
   assign rsp_body_count     = rsp.body_count;
   assign rsp_last_of_run    = rsp.last_of_run;

endmodule
